// File: rtl/core/bdd_pkg.sv
// shared types, constants and exp2 table for the box delta decoder
`timescale 1ns / 1ps
package bdd_pkg;
  localparam int unsigned CoordFracBits = 4;
  localparam int unsigned DeltaFracBits = 12;
  localparam int unsigned UnitShift = CoordFracBits + DeltaFracBits + 1;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam int unsigned ExpFracSel = 4;
  localparam int unsigned InterpBits = DeltaFracBits - ExpFracSel;
  // register stages in each axis pipeline
  localparam int unsigned PipeStages = 5;

  localparam logic [0:0] RegImageWidth = 1'b0;
  localparam logic [0:0] RegImageHeight = 1'b1;

  function automatic logic [17:0] pow2_frac(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0: r = 18'd65536;
      5'd1: r = 18'd68438;
      5'd2: r = 18'd71467;
      5'd3: r = 18'd74632;
      5'd4: r = 18'd77936;
      5'd5: r = 18'd81386;
      5'd6: r = 18'd84990;
      5'd7: r = 18'd88752;
      5'd8: r = 18'd92682;
      5'd9: r = 18'd96785;
      5'd10: r = 18'd101070;
      5'd11: r = 18'd105545;
      5'd12: r = 18'd110218;
      5'd13: r = 18'd115098;
      5'd14: r = 18'd120194;
      5'd15: r = 18'd125515;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] shift_x;
    logic [15:0] shift_y;
    logic [15:0] log_scale_w;
    logic [15:0] log_scale_h;
  } roi_item_t;

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
  } axis_out_t;

  // pipe control passed into each stage
  typedef struct packed {
    logic advance;
  } pipe_ctrl_t;
endpackage

// File: rtl/core/bdd_axis.sv
// one-axis decode pipeline: size/centre, exp mantissa, products, round and clip
`timescale 1ns / 1ps
module bdd_axis (
  input  logic               clk_i,
  input  bdd_pkg::pipe_ctrl_t ctrl_i,
  input  logic [15:0]        lo_i,
  input  logic [15:0]        hi_i,
  input  logic [15:0]        dc_i,
  input  logic [15:0]        ds_i,
  input  logic [12:0]        size_i,
  output bdd_pkg::axis_out_t res_o
);
  import bdd_pkg::*;

  // stage 1: size, twice centre, log2 product
  logic signed [17:0] w_d, w_q;
  logic signed [18:0] c2_d, c2_q;
  logic signed [15:0] dc1_q;
  logic signed [33:0] tprod_d, tprod_q;
  logic [12:0] size1_q;

  assign w_d = $signed({2'b00, hi_i}) - $signed({2'b00, lo_i})
               + 18'sd16;
  assign c2_d = $signed({2'b00, lo_i, 1'b0}) + 19'(w_d);
  assign tprod_d = $signed(ds_i) * $signed({1'b0, Log2eQ16});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      w_q <= w_d;
      c2_q <= c2_d;
      dc1_q <= $signed(dc_i);
      tprod_q <= tprod_d;
      size1_q <= size_i;
    end
  end

  // stage 2: mantissa via table interpolation, centre product
  logic signed [17:0] t2;
  logic signed [5:0] k2;
  logic [11:0] f2;
  logic [3:0] idx2;
  logic [7:0] r2;
  logic [17:0] m0, m1;
  logic [25:0] dm;
  logic [17:0] mant_d, mant_q;
  logic signed [5:0] k_q;
  logic signed [17:0] w2_q;
  logic signed [47:0] pc_d, pc_q;
  logic [12:0] size2_q;

  assign t2 = tprod_q[33:16];
  assign k2 = t2[17:12];
  assign f2 = t2[11:0];
  assign idx2 = f2[11:8];
  assign r2 = f2[7:0];
  assign m0 = pow2_frac({1'b0, idx2});
  assign m1 = pow2_frac({1'b0, idx2} + 5'd1);
  assign dm = (m1 - m0) * r2;
  assign mant_d = m0 + 18'(dm >> InterpBits);
  assign pc_d = 48'(dc1_q * $signed({w_q, 1'b0})) + (48'(c2_q) <<< DeltaFracBits);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      mant_q <= mant_d;
      k_q <= k2;
      w2_q <= w_q;
      pc_q <= pc_d;
      size2_q <= size1_q;
    end
  end

  // stage 3: w * mantissa
  logic signed [36:0] prod_d, prod_q;
  logic signed [5:0] k3_q;
  logic signed [47:0] pc3_q;
  logic [12:0] size3_q;

  assign prod_d = w2_q * $signed({1'b0, mant_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      prod_q <= prod_d;
      k3_q <= k_q;
      pc3_q <= pc_q;
      size3_q <= size2_q;
    end
  end

  // stage 4: scale by 2^(k-4) with rounding, form corner sums
  logic signed [6:0] s4;
  logic signed [63:0] hs4;
  logic signed [63:0] lo_sum_d, hi_sum_d, lo_sum_q, hi_sum_q;
  logic [12:0] size4_q;
  logic [5:0] rs4;
  logic signed [63:0] pe;

  assign s4 = 7'(k3_q) + 7'sd12 - 7'sd16;
  assign rs4 = 6'(-s4);
  assign pe = 64'(prod_q);
  always_comb begin
    if (s4 >= 0) hs4 = pe <<< s4[5:0];
    else hs4 = (pe + (64'sd1 <<< (rs4 - 6'd1))) >>> rs4;
  end
  assign lo_sum_d = 64'(pc3_q) - hs4;
  assign hi_sum_d = 64'(pc3_q) + hs4;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      lo_sum_q <= lo_sum_d;
      hi_sum_q <= hi_sum_d;
      size4_q <= size3_q;
    end
  end

  // stage 5: round to grid and clip
  function automatic logic [15:0] clip(input logic signed [63:0] q,
                                      input logic [12:0] sz);
    logic signed [63:0] v;
    logic signed [63:0] hib;
    logic signed [63:0] r;
    v = (q + (64'sd1 <<< (UnitShift - 1))) >>> UnitShift;
    hib = (64'(sz) - 64'sd1) <<< CoordFracBits;
    r = v;
    if (r > hib) r = hib;
    if (r < 0) r = 0;
    if (r > 64'sd65535) r = 64'sd65535;
    return r[15:0];
  endfunction

  axis_out_t res_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      res_q.lo <= clip(lo_sum_q, size4_q);
      res_q.hi <= clip(hi_sum_q, size4_q);
    end
  end
  assign res_o = res_q;
endmodule

// File: rtl/core/bbox_delta_decode_clip_core.sv
// top level: region box delta decode and clip, five-stage pipeline
`timescale 1ns / 1ps
// usage: region-class pairs enter on the s_axis group, one transfer per cycle
// at full rate unless m_axis stalls. tdata packs left, top, right, bottom,
// shift_x, shift_y, log_scale_w, log_scale_h (16 bits each, left lowest);
// tlast is frame_end. decoded corners leave on m_axis with tdata = left, top,
// right, bottom and tlast copying the input marker. m_axis_tvalid rises once
// the item has passed all five pipeline registers. throughput is one item per
// cycle unless m_axis stalls, set by the five-stage datapath (size and log2
// product, exp table interpolation, size product, scale and sum, round and
// clip). when m_axis_tready is low with a result waiting the whole pipe holds
// and s_axis_tready drops in the same cycle; bubbles inside the pipe are not
// squeezed out. reset clears all valid bits and sets both image sizes to 1024.
// cfg writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) must be made only while idle; the
// block does not enforce it. index 0 is image width, index 1 image height.
module bbox_delta_decode_clip_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata, // left, top, right, bottom, sx, sy, lsw, lsh
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata, // left, top, right, bottom
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [12:0]  cfg_wdata_i
);
  import bdd_pkg::*;

  logic [12:0] img_w_q, img_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 13'd1024;
      img_h_q <= 13'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth: img_w_q <= cfg_wdata_i;
        RegImageHeight: img_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [PipeStages-1:0] vld_q, last_q;
  logic stall, advance;
  // a valid result in the last stage with output stalled holds everything
  assign stall = vld_q[PipeStages-1] && !m_axis_tready;
  assign advance = !stall;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[PipeStages-2:0], s_axis_tvalid};
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) last_q <= {last_q[PipeStages-2:0], s_axis_tlast};
  end

  pipe_ctrl_t ctrl;
  assign ctrl.advance = advance;

  axis_out_t xres, yres;
  bdd_axis u_x (
    .clk_i, .ctrl_i(ctrl),
    .lo_i(s_axis_tdata[15:0]), .hi_i(s_axis_tdata[47:32]),
    .dc_i(s_axis_tdata[79:64]), .ds_i(s_axis_tdata[111:96]),
    .size_i(img_w_q), .res_o(xres)
  );
  bdd_axis u_y (
    .clk_i, .ctrl_i(ctrl),
    .lo_i(s_axis_tdata[31:16]), .hi_i(s_axis_tdata[63:48]),
    .dc_i(s_axis_tdata[95:80]), .ds_i(s_axis_tdata[127:112]),
    .size_i(img_h_q), .res_o(yres)
  );

  assign m_axis_tvalid = vld_q[PipeStages-1];
  assign m_axis_tlast = last_q[PipeStages-1];
  assign m_axis_tdata = {yres.hi, xres.hi, yres.lo, xres.lo};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipe moved during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && vld_q == '0 && m_axis_tready)
    |=> vld_q[0])
    else $error("accepted item lost");
endmodule
